/* rtl/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Types and constants shared by the receive-burst deframer.
// ----------------------------------------------------------------------------
package sed_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  localparam logic [7:0]  START_MARK    = 8'hAA;
  localparam logic [7:0]  END_MARK      = 8'h55;
  localparam logic [31:0] OVERHEAD      = 32'd10;

  // byte positions within a frame
  localparam logic [16:0] SOF_FIRST     = 17'd4;
  localparam logic [16:0] LEN_LO_POS    = 17'd8;
  localparam logic [16:0] LEN_HI_POS    = 17'd9;
  localparam logic [16:0] PAYLOAD_START = 17'd12;
  localparam logic [16:0] VERDICT_POS   = 17'd13;

  localparam int MAX_RESULTS  = 3;
  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_PTR_W    = $clog2(RES_FIFO_DEPTH);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] frame_len;
    logic [15:0] frames_in_burst;
    logic [31:0] total_errors;
    logic        run_last;
  } result_t;

  // results produced by one accepted byte, packed from slot 0
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                count;
  } result_set_t;

endpackage

/* rtl/sed_if.sv */
// ----------------------------------------------------------------------------
// sed_in_if / sed_out_if
// Valid/ready channels for burst bytes in and deframer results out.
// ----------------------------------------------------------------------------
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       burst_end;

  modport source (output valid, output rx_byte, output burst_end, input ready);
  modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

interface sed_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] frame_len;
  logic [15:0] frames_in_burst;
  logic [31:0] total_errors;
  logic        run_last;

  modport source (output valid, output kind, output payload_byte, output frame_len,
                  output frames_in_burst, output total_errors, output run_last,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_len,
                  input frames_in_burst, input total_errors, input run_last,
                  output ready);
endinterface

/* rtl/sed_parser.sv */
// ----------------------------------------------------------------------------
// sed_parser
// Frame parser state and the results caused by one accepted byte.
// ----------------------------------------------------------------------------
module sed_parser
  import sed_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        burst_end,
  output result_set_t set
);

  logic [16:0]            byte_in_frame, byte_in_frame_next;
  logic [31:0]            outer_length, outer_length_next;
  logic [15:0]            payload_length, payload_length_next;
  logic                   header_bad, header_bad_next;
  logic                   skip_rest, skip_rest_next;
  logic [15:0]            burst_frame_count, burst_frame_count_next;
  logic [COUNT_WIDTH-1:0] error_total, error_total_next;

  logic [16:0] payload_end;
  logic [16:0] frame_end;
  logic        reject;
  logic        done_frame;
  logic [1:0]  n;
  result_set_t set_comb;

  function automatic result_t make_result(kind_t k, logic [7:0] pb, logic [15:0] flen,
                                          logic [15:0] fib, logic [31:0] errs);
    result_t r;
    r.kind            = k;
    r.payload_byte    = pb;
    r.frame_len       = flen;
    r.frames_in_burst = fib;
    r.total_errors    = errs;
    r.run_last        = 1'b0;
    return r;
  endfunction

  assign payload_end = PAYLOAD_START + {1'b0, payload_length};
  assign frame_end   = VERDICT_POS + {1'b0, payload_length};

  always_comb begin
    byte_in_frame_next     = byte_in_frame;
    outer_length_next      = outer_length;
    payload_length_next    = payload_length;
    header_bad_next        = header_bad;
    skip_rest_next         = skip_rest;
    burst_frame_count_next = burst_frame_count;
    error_total_next       = error_total;
    set_comb               = '0;
    n                      = 2'd0;
    reject                 = 1'b0;
    done_frame             = 1'b0;

    if (!skip_rest) begin
      priority if (byte_in_frame < SOF_FIRST) begin
        outer_length_next = {outer_length[23:0], rx_byte};
      end else if (byte_in_frame < LEN_LO_POS) begin
        if (rx_byte != START_MARK) header_bad_next = 1'b1;
      end else if (byte_in_frame == LEN_LO_POS) begin
        payload_length_next = {8'h00, rx_byte};
      end else if (byte_in_frame == LEN_HI_POS) begin
        payload_length_next = {rx_byte, payload_length[7:0]};
        if (outer_length != {16'h0000, payload_length_next} + OVERHEAD) begin
          header_bad_next = 1'b1;
        end
      end else if (byte_in_frame >= PAYLOAD_START) begin
        if (byte_in_frame < payload_end) begin
          if (!header_bad) begin
            set_comb.res[n] = make_result(KIND_PAYLOAD, rx_byte, 16'h0000, 16'h0000,
                                          32'(error_total));
            n = n + 2'd1;
          end
        end else if (byte_in_frame == payload_end || byte_in_frame == frame_end) begin
          if (rx_byte != END_MARK) header_bad_next = 1'b1;
        end
      end else begin
        // reserved bytes
        header_bad_next = header_bad;
      end

      if (byte_in_frame >= VERDICT_POS) begin
        priority if (header_bad_next) reject = 1'b1;
        else if (byte_in_frame == frame_end) done_frame = 1'b1;
        else if (burst_end) reject = 1'b1;
        else reject = 1'b0;
      end

      if (reject) begin
        error_total_next = error_total + 1'b1;
        set_comb.res[n] = make_result(KIND_REJECT, 8'h00, payload_length_next, 16'h0000,
                                      32'(error_total_next));
        n = n + 2'd1;
        skip_rest_next      = 1'b1;
        byte_in_frame_next  = '0;
        outer_length_next   = '0;
        payload_length_next = '0;
        header_bad_next     = 1'b0;
      end else if (done_frame) begin
        burst_frame_count_next = burst_frame_count + 16'd1;
        set_comb.res[n] = make_result(KIND_ACCEPT, 8'h00, payload_length_next, 16'h0000,
                                      32'(error_total_next));
        n = n + 2'd1;
        byte_in_frame_next  = '0;
        outer_length_next   = '0;
        payload_length_next = '0;
        header_bad_next     = 1'b0;
      end else begin
        byte_in_frame_next = byte_in_frame + 17'd1;
      end
    end

    if (burst_end) begin
      set_comb.res[n] = make_result(KIND_DONE, 8'h00, 16'h0000, burst_frame_count_next,
                                    32'(error_total_next));
      n = n + 2'd1;
      byte_in_frame_next     = '0;
      outer_length_next      = '0;
      payload_length_next    = '0;
      header_bad_next        = 1'b0;
      skip_rest_next         = 1'b0;
      burst_frame_count_next = '0;
    end

    if (n != 2'd0) set_comb.res[n - 2'd1].run_last = 1'b1;
    set_comb.count = accept ? n : 2'd0;
  end

  assign set = set_comb;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_frame     <= '0;
      outer_length      <= '0;
      payload_length    <= '0;
      header_bad        <= 1'b0;
      skip_rest         <= 1'b0;
      burst_frame_count <= '0;
      error_total       <= '0;
    end else if (accept) begin
      byte_in_frame     <= byte_in_frame_next;
      outer_length      <= outer_length_next;
      payload_length    <= payload_length_next;
      header_bad        <= header_bad_next;
      skip_rest         <= skip_rest_next;
      burst_frame_count <= burst_frame_count_next;
      error_total       <= error_total_next;
    end
  end

endmodule

/* rtl/sed_result_fifo.sv */
// ----------------------------------------------------------------------------
// sed_result_fifo
// Small result queue: takes up to three results a cycle, gives one.
// ----------------------------------------------------------------------------
module sed_result_fifo
  import sed_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  result_set_t set,
  input  logic        pop,
  output result_t     head,
  output logic        not_empty,
  output logic        room
);

  result_t              mem [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_PTR_W:0]   count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  // room for a full set of results whatever the consumer does this cycle
  assign room      = (count <= (RES_PTR_W + 1)'(RES_FIFO_DEPTH - MAX_RESULTS));

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < set.count) mem[wr_ptr + RES_PTR_W'(k)] <= set.res[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(set.count);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop);
      count  <= count + (RES_PTR_W + 1)'(set.count) - (RES_PTR_W + 1)'(pop);
    end
  end

endmodule

/* rtl/spi_eth_frame_deframer.sv */
// ----------------------------------------------------------------------------
// spi_eth_frame_deframer
// Parses length-framed Ethernet frames from SPI receive bursts, passes
// payload bytes on and reports a verdict per frame and a done per burst.
// ----------------------------------------------------------------------------
//   channel  dir  carries
//   rx_in    in   rx_byte, burst_end
//   res_out  out  kind, payload_byte, frame_len, frames_in_burst,
//                 total_errors, run_last
//
// one byte is taken per cycle while rx_in.ready is high; each byte is parsed in
// the cycle it is taken and its results, up to three, go into a four-entry
// result queue. results leave one per cycle while res_out.ready is high, and
// rx_in.ready drops while the queue holds more than one result, so a byte
// that causes two or three results can hold off input; plain payload runs go at
// full rate. synchronous reset clears the parser state, counters and queue.
// ----------------------------------------------------------------------------
module spi_eth_frame_deframer
  import sed_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  sed_in_if.sink    rx_in,
  sed_out_if.source res_out
);

  result_set_t set;
  result_t     head;
  logic        accept;
  logic        pop;
  logic        not_empty;
  logic        room;

  assign rx_in.ready = room;
  assign accept      = rx_in.valid && room;
  assign pop         = res_out.ready && not_empty;

  sed_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_in.rx_byte),
    .burst_end (rx_in.burst_end),
    .set       (set)
  );

  sed_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .set       (set),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  assign res_out.valid           = not_empty;
  assign res_out.kind            = head.kind;
  assign res_out.payload_byte    = head.payload_byte;
  assign res_out.frame_len       = head.frame_len;
  assign res_out.frames_in_burst = head.frames_in_burst;
  assign res_out.total_errors    = head.total_errors;
  assign res_out.run_last        = head.run_last;

endmodule
